>>> design/ggp_pkg.sv
`default_nettype none
// ============================================================================
// ggp_pkg: shared types and constants for the go-to-goal controller
// Fixed-point formats, datapath widths, sequencer codes and the arctangent
// table of the iterative CORDIC.
// ============================================================================
package ggp_pkg;

  // Q format of positions, gains and speeds
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned GUARD_BITS    = 8;

  // Datapath widths
  localparam int unsigned ERR_W     = 33;  // position error, signed
  localparam int unsigned CW_W      = 44;  // CORDIC x/y, signed, guard bits included
  localparam int unsigned ZW        = 35;  // CORDIC angle, signed Q30
  localparam int unsigned X_LO_W    = 22;  // magnitude split for the 1/K product
  localparam int unsigned DIST_W    = 35;  // distance, unsigned
  localparam int unsigned THETA_W   = 22;  // bearing, signed Q.F
  localparam int unsigned TMP_W     = 37;  // first-stage position step, signed
  localparam int unsigned MAC_A_W   = 37;  // multiplier operand a, signed
  localparam int unsigned MAC_B_W   = 20;  // multiplier operand b, unsigned
  localparam int unsigned PROD_W    = MAC_A_W + MAC_B_W + 1;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned RND_W     = 48;  // rounded result
  localparam int unsigned LIN_W     = 32;
  localparam int unsigned ANG_W     = 19;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned LUT_IDX_W = 5;

  localparam int unsigned DIST_SHIFT  = 20 + GUARD_BITS;
  localparam int unsigned THETA_SHIFT = 30 - FRACTION_BITS;

  localparam int OMEGA_LIMIT = 205888;

  // 1/K of the CORDIC in Q20
  localparam logic [MAC_B_W-1:0] INV_GAIN_Q20 = 20'd636752;
  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  // atan(2^-i) in Q30
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  typedef struct packed {
    logic mul_en;    // register the product
    logic acc_en;    // update the accumulator
    logic acc_hi;    // load the product shifted up by the low-part width
    logic acc_add;   // add the product to the accumulator
    logic rnd_dist;  // round by the distance shift instead of the Q shift
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CORDIC,
    ST_MUL,
    ST_ACC,
    ST_STORE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_DIST_HI,
    OP_DIST_LO,
    OP_LIN,
    OP_ANG,
    OP_POS_X1,
    OP_POS_X2,
    OP_POS_Y1,
    OP_POS_Y2
  } mac_op_e;

  typedef enum logic [2:0] {
    REG_TARGET_X     = 3'd0,
    REG_TARGET_Y     = 3'd1,
    REG_REACH_RADIUS = 3'd2,
    REG_LINEAR_GAIN  = 3'd3,
    REG_ANGULAR_GAIN = 3'd4,
    REG_TIME_STEP    = 3'd5
  } reg_idx_e;

endpackage
`default_nettype wire

>>> design/ggp_cordic.sv
`default_nettype none
// ============================================================================
// ggp_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle; returns magnitude (times K) and angle in Q30.
// ============================================================================
module ggp_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ggp_pkg::ERR_W-1:0]  ex_i,
  input  logic signed [ggp_pkg::ERR_W-1:0]  ey_i,
  output logic                              done_o,
  output logic signed [ggp_pkg::CW_W-1:0]   mag_o,
  output logic signed [ggp_pkg::ZW-1:0]     ang_o
);
  import ggp_pkg::*;

  localparam int unsigned CntW = $clog2(STAGES);
  localparam logic [CntW-1:0] LastIter = CntW'(STAGES - 1);

  logic signed [CW_W-1:0] x_q, y_q, x_d, y_d, x0, y0, dx, dy;
  logic signed [ZW-1:0]   z_q, z_d, z0, atan_s;
  logic [CntW-1:0]        iter_q;
  logic [LUT_IDX_W-1:0]   lut_idx;
  logic                   run_q, done_q, zero_q;

  assign lut_idx = LUT_IDX_W'(iter_q);
  assign atan_s  = $signed(ZW'(ATAN_Q30[lut_idx]));

  // Pre-rotate into the right half plane
  always_comb begin
    x0 = CW_W'(ex_i) <<< GUARD_BITS;
    y0 = CW_W'(ey_i) <<< GUARD_BITS;
    z0 = '0;
    if (ex_i[ERR_W-1]) begin
      x0 = -x0;
      y0 = -y0;
      z0 = ey_i[ERR_W-1] ? -PI_Q30 : PI_Q30;
    end
  end

  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    if (!y_q[CW_W-1] && (y_q != '0)) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + atan_s;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - atan_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= run_q && (iter_q == LastIter);
      if (start_i) begin
        run_q  <= 1'b1;
        iter_q <= '0;
      end else if (run_q) begin
        if (iter_q == LastIter) begin
          run_q <= 1'b0;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      zero_q <= (ex_i == '0) && (ey_i == '0);
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign mag_o  = x_q;
  assign ang_o  = zero_q ? '0 : z_q;

endmodule
`default_nettype wire

>>> design/ggp_mac.sv
`default_nettype none
// ============================================================================
// ggp_mac: shared multiply-accumulate-round unit
// Registered product, a wide accumulator and round-to-nearest right shift.
// ============================================================================
module ggp_mac (
  input  logic                                clk_i,
  input  ggp_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [ggp_pkg::MAC_A_W-1:0]  a_i,
  input  logic [ggp_pkg::MAC_B_W-1:0]         b_i,
  output logic signed [ggp_pkg::RND_W-1:0]    rnd_o
);
  import ggp_pkg::*;

  localparam logic signed [ACC_W-1:0] HalfDist = ACC_W'(1) <<< (DIST_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] HalfQ    = ACC_W'(1) <<< (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, addend, rsum, shifted;

  always_comb begin
    addend = ctrl_i.acc_hi ? (ACC_W'(prod_q) <<< X_LO_W) : ACC_W'(prod_q);
    acc_d  = ctrl_i.acc_add ? (acc_q + addend) : addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * $signed({1'b0, b_i});
    end
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Round half up, then drop the fraction
  always_comb begin
    rsum    = acc_q + (ctrl_i.rnd_dist ? HalfDist : HalfQ);
    shifted = ctrl_i.rnd_dist ? (rsum >>> DIST_SHIFT) : (rsum >>> FRACTION_BITS);
  end

  assign rnd_o = shifted[RND_W-1:0];

endmodule
`default_nettype wire

>>> design/go_to_goal_p_controller.sv
`default_nettype none
// ============================================================================
// go_to_goal_p_controller: proportional go-to-goal controller
// Per control tick: CORDIC distance and bearing to the target, proportional
// linear and angular speed, reach detection and dead-reckoning update.
// ============================================================================
// Timing: restart and already-reached ticks give their result in the cycle after
//   acceptance; a normal tick runs the CORDIC, then the multiplier passes.
// Occupancy: one tick at a time, set by the CORDIC iterations and eight passes
//   through the shared multiplier (the distance high part skips the store step).
// Reset: position, reached flag and sequencer cleared; registers take their
//   documented reset values.
module go_to_goal_p_controller #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  // command output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ggp_pkg::LIN_W-1:0]            linear_speed_o,
  output logic signed [ggp_pkg::ANG_W-1:0]     angular_speed_o,
  output logic                                 target_reached_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ggp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import ggp_pkg::*;

  localparam int unsigned SUM_W = RND_W + 1;
  localparam logic signed [RND_W-1:0] OmegaMax = RND_W'(OMEGA_LIMIT);
  localparam logic signed [RND_W-1:0] OmegaMin = -OmegaMax;
  localparam logic signed [SUM_W-1:0] PosMax = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] PosMin = SUM_W'(32'sh80000000);
  localparam logic signed [ZW-1:0]    ThetaHalf = ZW'(1) <<< (THETA_SHIFT - 1);

  // --------------------------------------------------------------------------
  // Saturation helpers
  // --------------------------------------------------------------------------
  function automatic logic [LIN_W-1:0] sat_lin(input logic signed [RND_W-1:0] v);
    logic [LIN_W-1:0] r;
    if (v[RND_W-1]) begin
      r = '0;
    end else if (v[RND_W-2:LIN_W] != '0) begin
      r = '1;
    end else begin
      r = v[LIN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [RND_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > OmegaMax) begin
      r = OmegaMax[ANG_W-1:0];
    end else if (v < OmegaMin) begin
      r = OmegaMin[ANG_W-1:0];
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > PosMax) begin
      r = PosMax[POS_W-1:0];
    end else if (v < PosMin) begin
      r = PosMin[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] tgt_x_q, tgt_y_q;
  logic [30:0]             radius_q;
  logic [17:0]             lin_gain_q, ang_gain_q;
  logic [16:0]             tstep_q;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q    <= '0;
      tgt_y_q    <= '0;
      radius_q   <= 31'd6554;
      lin_gain_q <= 18'd32768;
      ang_gain_q <= 18'd32768;
      tstep_q    <= 17'd6554;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_X:     tgt_x_q    <= pwdata;
        REG_TARGET_Y:     tgt_y_q    <= pwdata;
        REG_REACH_RADIUS: radius_q   <= pwdata[30:0];
        REG_LINEAR_GAIN:  lin_gain_q <= pwdata[17:0];
        REG_ANGULAR_GAIN: ang_gain_q <= pwdata[17:0];
        REG_TIME_STEP:    tstep_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET_X:     prdata = tgt_x_q;
      REG_TARGET_Y:     prdata = tgt_y_q;
      REG_REACH_RADIUS: prdata = 32'(radius_q);
      REG_LINEAR_GAIN:  prdata = 32'(lin_gain_q);
      REG_ANGULAR_GAIN: prdata = 32'(ang_gain_q);
      REG_TIME_STEP:    prdata = 32'(tstep_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_e    state_q, state_d;
  mac_op_e   op_q, op_d;
  mac_ctrl_t mac_ctrl;
  logic      cordic_start, cordic_done, in_accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DIST_HI;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  logic reached_q;

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    cordic_start     = 1'b0;
    mac_ctrl         = '0;
    // Distance product: high half loads shifted, low half adds in
    mac_ctrl.acc_hi   = (op_q == OP_DIST_HI);
    mac_ctrl.acc_add  = (op_q == OP_DIST_LO);
    mac_ctrl.rnd_dist = (op_q == OP_DIST_LO);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // Restart and already-reached ticks skip the arithmetic entirely
          state_d = (restart_i || reached_q) ? ST_OUT : ST_START;
        end
      end
      ST_START: begin
        cordic_start = 1'b1;
        state_d      = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          op_d    = OP_DIST_HI;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (op_q == OP_DIST_HI) begin
          op_d    = OP_DIST_LO;
          state_d = ST_MUL;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (op_q == OP_POS_Y2) begin
          state_d = ST_OUT;
        end else begin
          op_d    = mac_op_e'(op_q + 3'd1);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // CORDIC and shared multiplier
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]   ex_q, ey_q;
  logic signed [CW_W-1:0]    cordic_mag;
  logic signed [ZW-1:0]      cordic_ang, theta_sum;
  logic signed [THETA_W-1:0] theta_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [TMP_W-1:0]   tmp_q;
  logic signed [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0]        mac_b;
  logic signed [RND_W-1:0]   rnd;

  ggp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .ex_i    (ex_q),
    .ey_i    (ey_q),
    .done_o  (cordic_done),
    .mag_o   (cordic_mag),
    .ang_o   (cordic_ang)
  );

  // Operand select for the current pass
  always_comb begin
    unique case (op_q) inside
      OP_DIST_HI: begin
        mac_a = MAC_A_W'(cordic_mag[CW_W-1:X_LO_W]);
        mac_b = INV_GAIN_Q20;
      end
      OP_DIST_LO: begin
        mac_a = MAC_A_W'(cordic_mag[X_LO_W-1:0]);
        mac_b = INV_GAIN_Q20;
      end
      OP_LIN: begin
        mac_a = MAC_A_W'(dist_q);
        mac_b = MAC_B_W'(lin_gain_q);
      end
      OP_ANG: begin
        mac_a = MAC_A_W'(theta_q);
        mac_b = MAC_B_W'(ang_gain_q);
      end
      OP_POS_X1: begin
        mac_a = MAC_A_W'(ex_q);
        mac_b = MAC_B_W'(lin_gain_q);
      end
      OP_POS_Y1: begin
        mac_a = MAC_A_W'(ey_q);
        mac_b = MAC_B_W'(lin_gain_q);
      end
      OP_POS_X2, OP_POS_Y2: begin
        mac_a = tmp_q;
        mac_b = MAC_B_W'(tstep_q);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  ggp_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .rnd_o  (rnd)
  );

  // Bearing from Q30 down to Q.F, round half up
  assign theta_sum = cordic_ang + ThetaHalf;

  // --------------------------------------------------------------------------
  // Controller state: position and reached flag
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [SUM_W-1:0] pos_x_sum, pos_y_sum;
  logic [DIST_W-1:0]       dist_now;

  assign pos_x_sum = SUM_W'(pos_x_q) + SUM_W'(rnd);
  assign pos_y_sum = SUM_W'(pos_y_q) + SUM_W'(rnd);
  assign dist_now  = rnd[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      reached_q <= 1'b0;
    end else if (in_accept && restart_i) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      reached_q <= 1'b0;
    end else if (state_q == ST_STORE) begin
      unique case (op_q) inside
        OP_DIST_LO: begin
          // Reaching tick still moves the position below
          if (dist_now < DIST_W'(radius_q)) begin
            reached_q <= 1'b1;
          end
        end
        OP_POS_X2: pos_x_q <= sat_pos(pos_x_sum);
        OP_POS_Y2: pos_y_q <= sat_pos(pos_y_sum);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Working registers and result registers
  // --------------------------------------------------------------------------
  logic [LIN_W-1:0]        lin_q;
  logic signed [ANG_W-1:0] ang_q;
  logic                    rch_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_q <= ERR_W'(tgt_x_q) - ERR_W'(pos_x_q);
      ey_q <= ERR_W'(tgt_y_q) - ERR_W'(pos_y_q);
      if (restart_i) begin
        lin_q <= '0;
        ang_q <= '0;
        rch_q <= 1'b0;
      end else if (reached_q) begin
        // Hold still once the goal is reached
        lin_q <= '0;
        ang_q <= '0;
        rch_q <= 1'b1;
      end
    end
    if ((state_q == ST_CORDIC) && cordic_done) begin
      theta_q <= THETA_W'(theta_sum >>> THETA_SHIFT);
    end
    if (state_q == ST_STORE) begin
      unique case (op_q) inside
        OP_DIST_LO:           dist_q <= dist_now;
        OP_LIN:               lin_q  <= sat_lin(rnd);
        OP_ANG:               ang_q  <= sat_ang(rnd);
        OP_POS_X1, OP_POS_Y1: tmp_q  <= rnd[TMP_W-1:0];
        OP_POS_Y2:            rch_q  <= reached_q;
        default: ;
      endcase
    end
  end

  assign linear_speed_o   = lin_q;
  assign angular_speed_o  = ang_q;
  assign target_reached_o = rch_q;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the go-to-goal proportional controller
// Drives control ticks through the valid/ready input, programs target, reach
// radius, gains and time step over the APB port between phases, and checks
// every command against a bit-true predictor of the controller.
// ============================================================================
module tb;

  localparam int     LIMIT_CYCLES = 1000000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     SETTLE       = 60;      // longer than a normal tick takes
  localparam longint U32_MAX      = 64'd4294967295;
  localparam longint S32_MAX      = 64'sd2147483647;
  localparam longint S32_MIN      = -64'sd2147483648;
  localparam longint OMEGA_MAX    = 64'sd205888;
  localparam longint PI_Q30_L     = 64'sd3373259426;
  localparam longint INV_K_Q20    = 64'sd636752;

  // atan(2^-i) in Q30, one entry per CORDIC stage
  localparam longint ATAN_TBL [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  typedef struct packed {
    logic [31:0]        lin;
    logic signed [18:0] ang;
    logic               reached;
  } cmd_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] linear_speed_o;
  logic signed [18:0] angular_speed_o;
  logic        target_reached_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [ggp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  go_to_goal_p_controller uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .linear_speed_o  (linear_speed_o),
    .angular_speed_o (angular_speed_o),
    .target_reached_o(target_reached_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the configuration registers, at their reset values
  longint tgt_x    = 0;
  longint tgt_y    = 0;
  longint radius   = 6554;
  longint lin_gain = 32768;
  longint ang_gain = 32768;
  longint dt_step  = 6554;

  // Shadow of the controller state
  longint pos_x   = 0;
  longint pos_y   = 0;
  bit     at_goal = 1'b0;

  logic   tick_queue [$];     // restart bits waiting to be driven
  cmd_t   cmd_expected [$];   // predicted commands, oldest first
  int     errors     = 0;
  int     cycles     = 0;
  int     ticks_sent = 0;
  logic   in_took    = 1'b0;  // input transaction completed at the last rising edge
  logic   calm       = 1'b0;  // no idling on either side while set
  logic   hold_req   = 1'b0;  // toggle to ask the receiver for a long hold-off
  logic   hold_ack   = 1'b0;
  int     hold_left  = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers and the controller predictor
  // ---------------------------------------------------------------------------
  // Round to nearest, ties towards +infinity, then arithmetic shift
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Vectoring CORDIC: magnitude (gain removed) and angle in Q30
  function automatic void cordic_polar(input longint ex, input longint ey,
                                       output longint mag, output longint ang);
    longint x, y, z, dx, dy;
    x = ex * 256;
    y = ey * 256;
    z = 0;
    if (ex == 0 && ey == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    // fold the left half-plane over, starting from +/- pi
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TBL[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TBL[i];
      end
    end
    mag = round_shift(x * INV_K_Q20, 28);
    ang = z;
  endfunction

  // Work out the command for one tick and advance the shadow state
  function automatic cmd_t predict_command(input logic restart);
    cmd_t   c;
    longint ex, ey, dist_m, theta, v, w, px, py;
    c = '0;
    if (restart) begin
      pos_x   = 0;
      pos_y   = 0;
      at_goal = 1'b0;
      return c;
    end
    // once at the goal: stop and hold position
    if (at_goal) begin
      c.reached = 1'b1;
      return c;
    end
    ex = tgt_x - pos_x;
    ey = tgt_y - pos_y;
    cordic_polar(ex, ey, dist_m, theta);
    theta = round_shift(theta, 14);
    v = clamp(round_shift(dist_m * lin_gain, 16), 0, U32_MAX);
    w = clamp(round_shift(theta * ang_gain, 16), -OMEGA_MAX, OMEGA_MAX);
    if (dist_m < radius) at_goal = 1'b1;
    // dead reckoning still runs on the tick that reaches the goal
    px = round_shift(round_shift(ex * lin_gain, 16) * dt_step, 16);
    py = round_shift(round_shift(ey * lin_gain, 16) * dt_step, 16);
    pos_x = clamp(pos_x + px, S32_MIN, S32_MAX);
    pos_y = clamp(pos_y + py, S32_MIN, S32_MAX);
    c.lin     = v[31:0];
    c.ang     = w[18:0];
    c.reached = at_goal;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: change at the falling edge, hold until the transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
    end else if (!(in_valid_i && !in_took)) begin
      // previous tick done or none offered: offer the next one or idle
      if (tick_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
        in_valid_i <= 1'b1;
        restart_i  <= tick_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        restart_i  <= 1'($urandom_range(0, 1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted tick, check each accepted command
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string name, input longint want, input longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    cmd_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL go_to_goal_p_controller");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o)
      cmd_expected.push_back(predict_command(restart_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_expected.size() == 0) begin
        flag_field("unexpected command", -1, longint'(linear_speed_o));
      end else begin
        want = cmd_expected.pop_front();
        if (linear_speed_o !== want.lin)
          flag_field("linear_speed", longint'(want.lin), longint'(linear_speed_o));
        if (angular_speed_o !== want.ang)
          flag_field("angular_speed", longint'(want.ang), longint'(angular_speed_o));
        if (target_reached_o !== want.reached)
          flag_field("target_reached", longint'(want.reached),
                     longint'(target_reached_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------
  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input ggp_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      ggp_pkg::REG_TARGET_X:     tgt_x    = longint'(signed'(val));
      ggp_pkg::REG_TARGET_Y:     tgt_y    = longint'(signed'(val));
      ggp_pkg::REG_REACH_RADIUS: radius   = longint'(val[30:0]);
      ggp_pkg::REG_LINEAR_GAIN:  lin_gain = longint'(val[17:0]);
      ggp_pkg::REG_ANGULAR_GAIN: ang_gain = longint'(val[17:0]);
      ggp_pkg::REG_TIME_STEP:    dt_step  = longint'(val[16:0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold the sender until every command has come back, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_queue.size() != 0 || in_valid_i || cmd_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] rad, input logic [31:0] lg,
                              input logic [31:0] ag, input logic [31:0] ts);
    wait_drained();
    cfg_write(ggp_pkg::REG_TARGET_X, tx);
    cfg_write(ggp_pkg::REG_TARGET_Y, ty);
    cfg_write(ggp_pkg::REG_REACH_RADIUS, rad);
    cfg_write(ggp_pkg::REG_LINEAR_GAIN, lg);
    cfg_write(ggp_pkg::REG_ANGULAR_GAIN, ag);
    cfg_write(ggp_pkg::REG_TIME_STEP, ts);
  endtask

  // Queue n ticks; bit i of the pattern is the restart bit of tick i
  task automatic queue_ticks(input logic [31:0] pattern, input int n);
    @(posedge clk_i);
    for (int i = 0; i < n; i++) begin
      tick_queue.push_back(pattern[i]);
      ticks_sent++;
    end
  endtask

  // Mostly plausible values, sometimes the extremes or raw random bits
  function automatic logic [31:0] pick_value(input ggp_pkg::reg_idx_e idx);
    int sel;
    sel = $urandom_range(0, 9);
    case (idx) inside
      ggp_pkg::REG_TARGET_X, ggp_pkg::REG_TARGET_Y:
        case (sel)
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return $urandom();
          default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
      ggp_pkg::REG_REACH_RADIUS:
        case (sel)
          0: return 32'h0;
          1: return 32'h7FFF_FFFF;
          2: return $urandom();
          default: return $urandom_range(64, 65536);
        endcase
      ggp_pkg::REG_TIME_STEP:
        case (sel)
          0: return 32'h0;
          1: return 32'd65536;
          2: return $urandom();
          default: return $urandom_range(1, 65536);
        endcase
      default:
        case (sel)
          0: return 32'h0;
          1: return 32'd131072;
          2: return $urandom();
          default: return $urandom_range(1, 131072);
        endcase
    endcase
  endfunction

  initial begin
    int           phase_no;
    int           n;
    logic [31:0]  pattern;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values, target at the origin: zero error reaches at once, then
    // the stop command repeats until a restart
    queue_ticks(32'b01001, 5);
    // Far corner, widest gains and step: saturate speed, turn rate and position
    apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h3FFFF, 32'h3FFFF, 32'h1FFFF);
    queue_ticks(32'b00001, 5);
    // Target straight behind on the negative x axis, widest radius
    apply_config(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'd131072, 32'd131072,
                 32'd65536);
    queue_ticks(32'b0001, 4);
    // Third quadrant with all gains zero: no motion, zero speeds, goal reached at once
    apply_config(-32'sd5, -32'sd1, 32'd6554, 32'h0, 32'h0, 32'h0);
    queue_ticks(32'b001, 3);
    // Bearing in the second quadrant with the turn gain high enough to clip
    apply_config(-32'sd65536, 32'sd196608, 32'd100, 32'd32768, 32'd131072, 32'd6554);
    queue_ticks(32'b00001, 5);

    // Random phases: mostly a restart first, then a run of ticks towards a fresh goal
    phase_no = 0;
    while (ticks_sent < 1020) begin
      apply_config(pick_value(ggp_pkg::REG_TARGET_X), pick_value(ggp_pkg::REG_TARGET_Y),
                   pick_value(ggp_pkg::REG_REACH_RADIUS),
                   pick_value(ggp_pkg::REG_LINEAR_GAIN),
                   pick_value(ggp_pkg::REG_ANGULAR_GAIN),
                   pick_value(ggp_pkg::REG_TIME_STEP));
      calm <= (phase_no == 6 || phase_no == 7);
      n = $urandom_range(8, 60);
      tick_queue.push_back($urandom_range(0, 9) < 7);
      ticks_sent++;
      for (int i = 1; i < n; i++) begin
        tick_queue.push_back($urandom_range(0, 99) < 4);
        ticks_sent++;
      end
      // stall the output for a long stretch while ticks keep coming
      if (phase_no == 3 || phase_no == 12) begin
        repeat (20) @(negedge clk_i);
        hold_req <= ~hold_req;
      end
      phase_no++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS go_to_goal_p_controller");
    end else begin
      $display("FAIL go_to_goal_p_controller");
    end
    $finish;
  end

endmodule
